[rtl/core/pts_pkg.sv]
package pts_pkg;

    localparam int NUM_TASKS_DEF      = 64;
    localparam int NUM_PRIORITIES_DEF = 3;

    localparam int OP_W     = 2;
    localparam int ID_W     = 6;
    localparam int PRIO_W   = 2;
    localparam int STATUS_W = 3;
    localparam int SEQ_W    = 32;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_SCHEDULE   = 2'd0;
    localparam logic [OP_W-1:0] OP_DESCHEDULE = 2'd1;
    localparam logic [OP_W-1:0] OP_TAKE       = 2'd2;

    localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RAISED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DELIVERED  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd6;

    typedef struct packed {
        logic capture;
        logic rd_id;
        logic check;
        logic scan_start;
        logic scan_issue;
        logic take_finish;
        logic no_work;
        logic clr_write;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            run_enable;
        logic            scan_last;
        logic            clr_last;
        logic            out_free;
    } t_ctrl_sts;

endpackage

[rtl/core/pts_ram.sv]
module pts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/core/pts_ctrl.sv]
module pts_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  pts_pkg::t_ctrl_sts    i_sts,
    output pts_pkg::t_ctrl_cmd    o_cmd
);

    localparam logic [2:0] S_CLEAR     = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_READ      = 3'd2;
    localparam logic [2:0] S_CHECK     = 3'd3;
    localparam logic [2:0] S_SCAN      = 3'd4;
    localparam logic [2:0] S_SCAN_WAIT = 3'd5;
    localparam logic [2:0] S_TAKE      = 3'd6;
    localparam logic [2:0] S_DONE      = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                unique case (i_sts.op) inside
                    pts_pkg::OP_SCHEDULE, pts_pkg::OP_DESCHEDULE: begin
                        o_cmd.rd_id = 1'b1;
                        n_state     = S_CHECK;
                    end
                    pts_pkg::OP_TAKE: begin
                        if (i_sts.run_enable) begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end else begin
                            o_cmd.no_work = 1'b1;
                            n_state       = S_DONE;
                        end
                    end
                    default: begin
                        o_cmd.no_work = 1'b1;
                        n_state       = S_DONE;
                    end
                endcase
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_DONE;
            end
            S_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_WAIT;
                end
            end
            S_SCAN_WAIT: begin
                n_state = S_TAKE;
            end
            S_TAKE: begin
                o_cmd.take_finish = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule

[rtl/core/pts_datapath.sv]
module pts_datapath #(
    parameter int NUM_TASKS      = pts_pkg::NUM_TASKS_DEF,
    parameter int NUM_PRIORITIES = pts_pkg::NUM_PRIORITIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [pts_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_data,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [pts_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  pts_pkg::t_ctrl_cmd             i_cmd,
    output pts_pkg::t_ctrl_sts             o_sts
);

    localparam int AW = $clog2(NUM_TASKS);
    localparam int PW = $clog2(NUM_PRIORITIES);
    localparam int SW = pts_pkg::SEQ_W;
    localparam int DW = 1 + PW + SW;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_TASKS - 1);
    localparam logic [PW-1:0] TOP_PRIO = PW'(NUM_PRIORITIES - 1);

    logic [pts_pkg::OP_W-1:0]     in_op;
    logic [pts_pkg::ID_W-1:0]     in_id;
    logic [pts_pkg::PRIO_W-1:0]   in_pr;
    logic [PW-1:0]                in_pr_sat;

    logic [pts_pkg::OP_W-1:0]     r_op;
    logic [pts_pkg::ID_W-1:0]     r_id;
    logic                         r_id_ok;
    logic [PW-1:0]                r_pr;
    logic                         r_run_enable;
    logic [SW-1:0]                r_seq_cnt;
    logic [SW-1:0]                n_seq_cnt;

    logic [pts_pkg::STATUS_W-1:0] r_res_status;
    logic [pts_pkg::ID_W-1:0]     r_res_task;
    logic [pts_pkg::STATUS_W-1:0] n_res_status;

    logic [AW-1:0]                r_scan_idx;
    logic                         r_eval_vld;
    logic [AW-1:0]                r_eval_idx;
    logic                         r_found;
    logic [AW-1:0]                r_best_idx;
    logic [PW-1:0]                r_best_pri;
    logic [SW-1:0]                r_best_seq;
    logic [AW-1:0]                r_clr_idx;

    logic                         r_out_valid;
    logic [pts_pkg::STATUS_W-1:0] r_out_status;
    logic [pts_pkg::ID_W-1:0]     r_out_task;

    logic [AW-1:0]                id_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [DW-1:0]                wr_data;
    logic [AW-1:0]                rd_addr;
    logic [DW-1:0]                rd_data;
    logic                         rd_queued;
    logic [PW-1:0]                rd_pri;
    logic [SW-1:0]                rd_seq;
    logic [SW-1:0]                seq_diff;
    logic                         better;
    logic                         out_free;

    assign in_op = i_s_tdata[1:0];
    assign in_id = i_s_tdata[7:2];
    assign in_pr = i_s_tdata[9:8];
    assign in_pr_sat = (int'(in_pr) >= NUM_PRIORITIES) ? TOP_PRIO : PW'(in_pr);

    assign id_addr   = AW'(r_id);
    assign rd_queued = rd_data[DW-1];
    assign rd_pri    = rd_data[SW +: PW];
    assign rd_seq    = rd_data[SW-1:0];
    assign seq_diff  = rd_seq - r_best_seq;
    assign better    = !r_found || (rd_pri > r_best_pri) ||
                       ((rd_pri == r_best_pri) && seq_diff[SW-1]);
    assign out_free  = !r_out_valid || i_m_tready;
    assign rd_addr   = i_cmd.rd_id ? id_addr : r_scan_idx;

    pts_ram #(
        .WIDTH (DW),
        .DEPTH (NUM_TASKS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        wr_en        = 1'b0;
        wr_addr      = id_addr;
        wr_data      = '0;
        n_seq_cnt    = r_seq_cnt;
        n_res_status = r_res_status;
        if (i_cmd.clr_write) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_idx;
        end else if (i_cmd.check) begin
            if (r_op == pts_pkg::OP_SCHEDULE) begin
                n_res_status = pts_pkg::ST_IGNORED;
                if (r_id_ok && (!rd_queued || (rd_pri < r_pr))) begin
                    n_seq_cnt    = r_seq_cnt + 1'b1;
                    wr_en        = 1'b1;
                    wr_data      = {1'b1, r_pr, n_seq_cnt};
                    n_res_status = rd_queued ? pts_pkg::ST_RAISED : pts_pkg::ST_QUEUED;
                end
            end else begin
                n_res_status = pts_pkg::ST_NOT_QUEUED;
                if (r_id_ok && rd_queued) begin
                    wr_en        = 1'b1;
                    n_res_status = pts_pkg::ST_REMOVED;
                end
            end
        end else if (i_cmd.take_finish) begin
            wr_addr      = r_best_idx;
            wr_en        = r_found;
            n_res_status = r_found ? pts_pkg::ST_DELIVERED : pts_pkg::ST_EMPTY;
        end else if (i_cmd.no_work) begin
            n_res_status = (r_op == pts_pkg::OP_TAKE) ? pts_pkg::ST_EMPTY
                                                     : pts_pkg::ST_IGNORED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_enable <= 1'b1;
            r_seq_cnt    <= '0;
            r_clr_idx    <= '0;
            r_eval_vld   <= 1'b0;
            r_found      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_run_enable <= i_cfg_data;
            end
            r_seq_cnt  <= n_seq_cnt;
            r_eval_vld <= i_cmd.scan_issue;
            if (i_cmd.clr_write) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_found <= 1'b0;
            end else if (r_eval_vld && rd_queued && better) begin
                r_found <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= in_op;
            r_id    <= in_id;
            r_id_ok <= (int'(in_id) < NUM_TASKS);
            r_pr    <= in_pr_sat;
        end
        if (i_cmd.scan_start) begin
            r_scan_idx <= '0;
        end else if (i_cmd.scan_issue) begin
            r_scan_idx <= r_scan_idx + 1'b1;
        end
        r_eval_idx <= r_scan_idx;
        if (r_eval_vld && rd_queued && better) begin
            r_best_idx <= r_eval_idx;
            r_best_pri <= rd_pri;
            r_best_seq <= rd_seq;
        end
        r_res_status <= n_res_status;
        if (i_cmd.check || i_cmd.no_work) begin
            r_res_task <= '0;
        end else if (i_cmd.take_finish) begin
            r_res_task <= r_found ? pts_pkg::ID_W'(r_best_idx) : '0;
        end
        if (i_cmd.emit) begin
            r_out_status <= r_res_status;
            r_out_task   <= r_res_task;
        end
    end

    assign o_sts.op         = r_op;
    assign o_sts.run_enable = r_run_enable;
    assign o_sts.scan_last  = (r_scan_idx == LAST_IDX);
    assign o_sts.clr_last   = (r_clr_idx == LAST_IDX);
    assign o_sts.out_free   = out_free;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(pts_pkg::M_TDATA_W - pts_pkg::STATUS_W - pts_pkg::ID_W){1'b0}},
                         r_out_task, r_out_status};

endmodule

[rtl/core/priority_task_scheduler.sv]
// Priority task scheduler with first-in-first-out order inside each priority. Each request
// on the input stream schedules, deschedules or takes the next task, and gives exactly one
// response on the output stream. Schedule and deschedule read the task's slot and check it
// before the response is offered, a take-next while halted or an unknown operation is
// answered without a table read, and an enabled take-next first scans the slot table,
// which reads one slot per cycle from its single-read-port memory. The next request can be
// accepted in the same cycle as the response is offered. A response waits in the output
// register while the receiver stalls; the block still takes the next request and stalls
// only once the following response is ready behind it. After reset a clearing pass empties
// the table before the first request is accepted; the run enable register may be written at
// any time while the block is idle.
module priority_task_scheduler #(
    parameter int NUM_TASKS      = pts_pkg::NUM_TASKS_DEF,
    parameter int NUM_PRIORITIES = pts_pkg::NUM_PRIORITIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // operation [1:0], task_id [7:2], priority_req [9:8], zero above.
    input  logic [pts_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // status [2:0], task_out [8:3], zero above.
    output logic [pts_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_data
);

    pts_pkg::t_ctrl_cmd cmd;
    pts_pkg::t_ctrl_sts sts;
    logic               s_ready;

    pts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (s_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pts_datapath #(
        .NUM_TASKS      (NUM_TASKS),
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign o_s_axis_tready = s_ready;
    assign o_cfg_ready     = 1'b1;

endmodule
